// ----- src/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pad poll packer package
// Shared widths, register indexes, mode codes and the pad item types used by
// the channel interfaces and the modules of the pad poll response packer.
// ----------------------------------------------------------------------------
package ppr_pkg;

   // Configuration port geometry and register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD = 1'd1;

   // Register reset values.
   localparam logic [7:0]  MODE_RESET = 8'd3;
   localparam logic [31:0] HOLD_RESET = 32'd1458000000;

   // Low word packing modes.
   localparam logic [7:0] MODE_NIBBLE_ALL  = 8'd0;
   localparam logic [7:0] MODE_FULL_TRIG   = 8'd1;
   localparam logic [7:0] MODE_FULL_ANALOG = 8'd2;
   localparam logic [7:0] MODE_NO_ANALOG   = 8'd3;
   localparam logic [7:0] MODE_NO_TRIG     = 8'd4;
   localparam logic [7:0] MODE_ALIAS_5     = 8'd5;
   localparam logic [7:0] MODE_ALIAS_6     = 8'd6;
   localparam logic [7:0] MODE_ALIAS_7     = 8'd7;

   // Item kinds.
   localparam logic KIND_POLL        = 1'b0;
   localparam logic KIND_ORIGIN_READ = 1'b1;

   // Combo button patterns on the upper byte of the button word.
   localparam logic [7:0] COMBO_MASK_ORIGIN = 8'h1C; // start, Y, X
   localparam logic [7:0] COMBO_MASK_RESET  = 8'h16; // start, X, B

   // The high word of a poll response always carries this marker bit.
   localparam logic [31:0] HI_MARKER = 32'h0080_0000;

   // Origin reset values.
   localparam logic [7:0] ORIGIN_STICK_RESET = 8'h80;
   localparam logic [7:0] ORIGIN_TRIG_RESET  = 8'h1F;

   // Button combo being tracked.
   typedef enum logic [1:0] {
      TRACK_IDLE     = 2'd0,
      TRACK_RECENTER = 2'd1,
      TRACK_RESTART  = 2'd2
   } combo_type;

   // One poll request.
   typedef struct packed {
      logic        kind;
      logic [31:0] time_ticks;
      logic [15:0] buttons;
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
      logic [7:0]  substick_x;
      logic [7:0]  substick_y;
      logic [7:0]  trigger_left;
      logic [7:0]  trigger_right;
      logic [7:0]  analog_a;
      logic [7:0]  analog_b;
   } req_item_type;

   // One poll response.
   typedef struct packed {
      logic [31:0] word_hi;
      logic [31:0] word_lo;
      logic        reset_tap;
      logic [7:0]  origin_stick_x;
      logic [7:0]  origin_stick_y;
      logic [7:0]  origin_substick_x;
      logic [7:0]  origin_substick_y;
      logic [7:0]  origin_trigger_left;
      logic [7:0]  origin_trigger_right;
   } rsp_item_type;

endpackage

// ----- src/ppr_channels.sv -----
// ----------------------------------------------------------------------------
// Pad poll packer channels
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------

// Request channel: one pad poll or origin read per transaction.
interface ppr_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] time_ticks;
   logic [15:0] buttons;
   logic [7:0]  stick_x;
   logic [7:0]  stick_y;
   logic [7:0]  substick_x;
   logic [7:0]  substick_y;
   logic [7:0]  trigger_left;
   logic [7:0]  trigger_right;
   logic [7:0]  analog_a;
   logic [7:0]  analog_b;

   modport source (
      output valid, kind, time_ticks, buttons, stick_x, stick_y, substick_x,
             substick_y, trigger_left, trigger_right, analog_a, analog_b,
      input  ready
   );
   modport sink (
      input  valid, kind, time_ticks, buttons, stick_x, stick_y, substick_x,
             substick_y, trigger_left, trigger_right, analog_a, analog_b,
      output ready
   );
endinterface

// Response channel: one packed response per transaction.
interface ppr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_hi;
   logic [31:0] word_lo;
   logic        reset_tap;
   logic [7:0]  origin_stick_x;
   logic [7:0]  origin_stick_y;
   logic [7:0]  origin_substick_x;
   logic [7:0]  origin_substick_y;
   logic [7:0]  origin_trigger_left;
   logic [7:0]  origin_trigger_right;

   modport source (
      output valid, word_hi, word_lo, reset_tap, origin_stick_x, origin_stick_y,
             origin_substick_x, origin_substick_y, origin_trigger_left,
             origin_trigger_right,
      input  ready
   );
   modport sink (
      input  valid, word_hi, word_lo, reset_tap, origin_stick_x, origin_stick_y,
             origin_substick_x, origin_substick_y, origin_trigger_left,
             origin_trigger_right,
      output ready
   );
endinterface

// Register write channel.
interface ppr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ppr_pkg::CSR_INDEX_W-1:0] index;
   logic [ppr_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/ppr_packer.sv -----
// ----------------------------------------------------------------------------
// Pad poll word packer
// Builds the high response word and the mode-dependent low response word
// from one pad state.
// ----------------------------------------------------------------------------
module ppr_packer (
   input  logic [7:0]  mode,
   input  logic [15:0] buttons,
   input  logic [7:0]  stick_x,
   input  logic [7:0]  stick_y,
   input  logic [7:0]  substick_x,
   input  logic [7:0]  substick_y,
   input  logic [7:0]  trigger_left,
   input  logic [7:0]  trigger_right,
   input  logic [7:0]  analog_a,
   input  logic [7:0]  analog_b,
   output logic [31:0] word_hi,
   output logic [31:0] word_lo
);

   // High word: buttons, main stick and the fixed marker bit.
   assign word_hi = {buttons, stick_x, stick_y} | ppr_pkg::HI_MARKER;

   // Low word: the mode picks full bytes or top nibbles for each analog value.
   always_comb begin
      case (mode)
         ppr_pkg::MODE_NIBBLE_ALL, ppr_pkg::MODE_ALIAS_5,
         ppr_pkg::MODE_ALIAS_6, ppr_pkg::MODE_ALIAS_7: begin
            word_lo = {substick_x, substick_y, trigger_left[7:4],
                       trigger_right[7:4], analog_a[7:4], analog_b[7:4]};
         end
         ppr_pkg::MODE_FULL_TRIG: begin
            word_lo = {substick_x[7:4], substick_y[7:4], trigger_left,
                       trigger_right, analog_a[7:4], analog_b[7:4]};
         end
         ppr_pkg::MODE_FULL_ANALOG: begin
            word_lo = {substick_x[7:4], substick_y[7:4], trigger_left[7:4],
                       trigger_right[7:4], analog_a, analog_b};
         end
         ppr_pkg::MODE_NO_ANALOG: begin
            word_lo = {substick_x, substick_y, trigger_left, trigger_right};
         end
         ppr_pkg::MODE_NO_TRIG: begin
            word_lo = {substick_x, substick_y, analog_a, analog_b};
         end
         default: begin
            word_lo = 32'd0;
         end
      endcase
   end

endmodule

// ----- src/pad_poll_response_packer_unit.sv -----
// ----------------------------------------------------------------------------
// Pad poll response packer
// Packs pad state into response words, tracks the origin and reset button
// combos and answers origin reads with the stored origin.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  carries one transaction per poll (kind 0) or origin read (kind 1).
//   rsp_ch  returns exactly one response transaction per request, in order.
//   csr_ch  writes the mode register (index 0) and the hold time (index 1);
//           it is always ready and should be used only while the unit is idle.
// Pipeline: an accepted request is held in the request register, then packed
//   and written into the response register as soon as that register is
//   free; the response then stays valid until the receiver takes it.
// Throughput: one transaction per cycle while rsp_ch.ready stays high; the
//   combo tracker updates its state once per poll, combinationally, in the packing stage.
// Stalls: when the receiver holds rsp_ch.ready low, the response register
//   holds its contents and the request register fills; req_ch.ready then
//   drops until the response is taken. Nothing is dropped or repeated.
// Reset: clears both stages, sets mode 3 and the default hold time, clears
//   the combo tracker and restores the origin to centered sticks and 0x1F
//   triggers.
// ----------------------------------------------------------------------------
module pad_poll_response_packer_unit (
   input  logic      clock,
   input  logic      reset,
   ppr_req_if.sink   req_ch,
   ppr_rsp_if.source rsp_ch,
   ppr_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [7:0]  mode_ff;
   logic [31:0] hold_ff;

   // Request stage.
   logic                  s1_valid_ff;
   ppr_pkg::req_item_type s1_item_ff;

   // Response stage.
   logic                  out_valid_ff;
   ppr_pkg::rsp_item_type out_item_ff;
   ppr_pkg::rsp_item_type out_item_in;

   // Combo tracker and stored origin.
   ppr_pkg::combo_type combo_seen_ff, combo_seen_in, combo_mid;
   logic [31:0]        combo_start_ff, combo_start_in, combo_start_mid;
   logic [7:0]         org_sx_ff, org_sy_ff, org_cx_ff, org_cy_ff;
   logic [7:0]         org_tl_ff, org_tr_ff;

   // Handshake and packing signals.
   logic               out_free;
   logic               advance;
   ppr_pkg::combo_type combo_now;
   logic [31:0]        elapsed;
   logic               is_poll;
   logic               fire;
   logic               capture;
   logic               tap;
   logic [31:0]        word_hi;
   logic [31:0]        word_lo;

   // Pipeline handshake: the request stage moves when the response register
   // is empty or being drained.
   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign advance       = s1_valid_ff && out_free;
   assign req_ch.ready  = !s1_valid_ff || out_free;
   assign csr_ch.ready  = 1'b1;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff <= '{kind:          req_ch.kind,
                         time_ticks:    req_ch.time_ticks,
                         buttons:       req_ch.buttons,
                         stick_x:       req_ch.stick_x,
                         stick_y:       req_ch.stick_y,
                         substick_x:    req_ch.substick_x,
                         substick_y:    req_ch.substick_y,
                         trigger_left:  req_ch.trigger_left,
                         trigger_right: req_ch.trigger_right,
                         analog_a:      req_ch.analog_a,
                         analog_b:      req_ch.analog_b};
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ppr_pkg::MODE_RESET;
         hold_ff <= ppr_pkg::HOLD_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            ppr_pkg::REG_MODE: mode_ff <= csr_ch.data[7:0];
            ppr_pkg::REG_HOLD: hold_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Word packing.
   ppr_packer u_packer (
      .mode          (mode_ff),
      .buttons       (s1_item_ff.buttons),
      .stick_x       (s1_item_ff.stick_x),
      .stick_y       (s1_item_ff.stick_y),
      .substick_x    (s1_item_ff.substick_x),
      .substick_y    (s1_item_ff.substick_y),
      .trigger_left  (s1_item_ff.trigger_left),
      .trigger_right (s1_item_ff.trigger_right),
      .analog_a      (s1_item_ff.analog_a),
      .analog_b      (s1_item_ff.analog_b),
      .word_hi       (word_hi),
      .word_lo       (word_lo)
   );

   // Classify the buttons held on this poll.
   always_comb begin
      if (s1_item_ff.buttons[15:8] == ppr_pkg::COMBO_MASK_ORIGIN) begin
         combo_now = ppr_pkg::TRACK_RECENTER;
      end else if (s1_item_ff.buttons[15:8] == ppr_pkg::COMBO_MASK_RESET) begin
         combo_now = ppr_pkg::TRACK_RESTART;
      end else begin
         combo_now = ppr_pkg::TRACK_IDLE;
      end
   end

   // Restart the hold timer when a new combo appears, then check the hold time.
   always_comb begin
      is_poll         = (s1_item_ff.kind == ppr_pkg::KIND_POLL);
      combo_mid       = combo_seen_ff;
      combo_start_mid = combo_start_ff;
      if (combo_now != combo_seen_ff) begin
         combo_mid = combo_now;
         if (combo_now != ppr_pkg::TRACK_IDLE) begin
            combo_start_mid = s1_item_ff.time_ticks;
         end
      end
      elapsed  = s1_item_ff.time_ticks - combo_start_mid;
      fire     = is_poll && (combo_mid != ppr_pkg::TRACK_IDLE) && (elapsed > hold_ff);
      tap      = fire && (combo_mid == ppr_pkg::TRACK_RESTART);
      capture  = fire && (combo_mid == ppr_pkg::TRACK_RECENTER);
      combo_seen_in  = fire ? ppr_pkg::TRACK_IDLE : combo_mid;
      combo_start_in = combo_start_mid;
   end

   // Response payload; origin fields show a capture made on this same poll.
   always_comb begin
      out_item_in.word_hi              = is_poll ? word_hi : 32'd0;
      out_item_in.word_lo              = is_poll ? word_lo : 32'd0;
      out_item_in.reset_tap            = tap;
      out_item_in.origin_stick_x       = capture ? s1_item_ff.stick_x : org_sx_ff;
      out_item_in.origin_stick_y       = capture ? s1_item_ff.stick_y : org_sy_ff;
      out_item_in.origin_substick_x    = capture ? s1_item_ff.substick_x : org_cx_ff;
      out_item_in.origin_substick_y    = capture ? s1_item_ff.substick_y : org_cy_ff;
      out_item_in.origin_trigger_left  = capture ? s1_item_ff.trigger_left : org_tl_ff;
      out_item_in.origin_trigger_right = capture ? s1_item_ff.trigger_right : org_tr_ff;
   end

   // Combo tracker and origin state advance once per item, polls only.
   always_ff @(posedge clock) begin
      if (reset) begin
         combo_seen_ff  <= ppr_pkg::TRACK_IDLE;
         combo_start_ff <= 32'd0;
         org_sx_ff      <= ppr_pkg::ORIGIN_STICK_RESET;
         org_sy_ff      <= ppr_pkg::ORIGIN_STICK_RESET;
         org_cx_ff      <= ppr_pkg::ORIGIN_STICK_RESET;
         org_cy_ff      <= ppr_pkg::ORIGIN_STICK_RESET;
         org_tl_ff      <= ppr_pkg::ORIGIN_TRIG_RESET;
         org_tr_ff      <= ppr_pkg::ORIGIN_TRIG_RESET;
      end else if (advance && is_poll) begin
         combo_seen_ff  <= combo_seen_in;
         combo_start_ff <= combo_start_in;
         if (capture) begin
            org_sx_ff <= s1_item_ff.stick_x;
            org_sy_ff <= s1_item_ff.stick_y;
            org_cx_ff <= s1_item_ff.substick_x;
            org_cy_ff <= s1_item_ff.substick_y;
            org_tl_ff <= s1_item_ff.trigger_left;
            org_tr_ff <= s1_item_ff.trigger_right;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.word_hi              = out_item_ff.word_hi;
   assign rsp_ch.word_lo              = out_item_ff.word_lo;
   assign rsp_ch.reset_tap            = out_item_ff.reset_tap;
   assign rsp_ch.origin_stick_x       = out_item_ff.origin_stick_x;
   assign rsp_ch.origin_stick_y       = out_item_ff.origin_stick_y;
   assign rsp_ch.origin_substick_x    = out_item_ff.origin_substick_x;
   assign rsp_ch.origin_substick_y    = out_item_ff.origin_substick_y;
   assign rsp_ch.origin_trigger_left  = out_item_ff.origin_trigger_left;
   assign rsp_ch.origin_trigger_right = out_item_ff.origin_trigger_right;

`ifndef SYNTHESIS
   // A reset tap only comes from a poll, which always sets the marker bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.reset_tap |-> rsp_ch.word_hi[23])
      else $error("reset tap on a response without the poll marker");

   // Origin reads answer with zero words and no tap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.word_hi[23]
         |-> (rsp_ch.word_lo == 32'd0) && !rsp_ch.reset_tap)
      else $error("origin read response carries packed data");

   // A combo that acts is cleared afterwards.
   assert property (@(posedge clock) disable iff (reset)
      advance && fire |=> combo_seen_ff == ppr_pkg::TRACK_IDLE)
      else $error("combo still tracked after it acted");

   // A request waiting on a stalled response stage is kept.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("request stage lost an item while stalled");
`endif

endmodule

// ----- tb/sv/pad_poll_response_packer_checker.sv -----
// ----------------------------------------------------------------------------
// Pad poll response packer checker
// Watches the request, response and register channels of the packer. It keeps
// its own copy of the mode, the hold time, the combo tracker and the stored
// origin. It predicts one response per accepted request and compares every
// accepted response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pad_poll_response_packer_checker (
   input  logic clock,
   input  logic reset,
   ppr_req_if   req_ch,
   ppr_rsp_if   rsp_ch,
   ppr_csr_if   csr_ch,
   output int   error_count,
   output int   pending
);
   import ppr_pkg::*;

   // Shadow registers and combo tracker.
   logic [7:0]  mode_reg;
   logic [31:0] hold_reg;
   combo_type   combo_seen;
   logic [31:0] combo_start;
   logic [7:0]  org_stick_x, org_stick_y, org_sub_x, org_sub_y;
   logic [7:0]  org_trig_l, org_trig_r;

   // Responses still owed by the block, oldest first.
   rsp_item_type owed_responses[$];
   rsp_item_type got_rsp;
   rsp_item_type due_rsp;
   req_item_type seen_req;

   // Low word layout for each packing mode; a nibble is the top four bits.
   function automatic logic [31:0] packed_low_word(input logic [7:0] m,
                                                   input req_item_type r);
      case (m)
         MODE_NIBBLE_ALL, MODE_ALIAS_5, MODE_ALIAS_6, MODE_ALIAS_7:
            return {r.substick_x, r.substick_y, r.trigger_left[7:4],
                    r.trigger_right[7:4], r.analog_a[7:4], r.analog_b[7:4]};
         MODE_FULL_TRIG:
            return {r.substick_x[7:4], r.substick_y[7:4], r.trigger_left,
                    r.trigger_right, r.analog_a[7:4], r.analog_b[7:4]};
         MODE_FULL_ANALOG:
            return {r.substick_x[7:4], r.substick_y[7:4], r.trigger_left[7:4],
                    r.trigger_right[7:4], r.analog_a, r.analog_b};
         MODE_NO_ANALOG:
            return {r.substick_x, r.substick_y, r.trigger_left, r.trigger_right};
         MODE_NO_TRIG:
            return {r.substick_x, r.substick_y, r.analog_a, r.analog_b};
         default:
            return 32'd0;
      endcase
   endfunction

   // Work out the response to one request and advance the combo tracker.
   task automatic predict_poll_response(input req_item_type r);
      rsp_item_type rsp;
      combo_type    now_combo;
      rsp = '0;
      if (r.kind == KIND_POLL) begin
         rsp.word_hi = {r.buttons, r.stick_x, r.stick_y} | HI_MARKER;
         rsp.word_lo = packed_low_word(mode_reg, r);
         if (r.buttons[15:8] == COMBO_MASK_ORIGIN) begin
            now_combo = TRACK_RECENTER;
         end else if (r.buttons[15:8] == COMBO_MASK_RESET) begin
            now_combo = TRACK_RESTART;
         end else begin
            now_combo = TRACK_IDLE;
         end
         // A new combo restarts the hold timer.
         if (now_combo != combo_seen) begin
            combo_seen = now_combo;
            if (now_combo != TRACK_IDLE) begin
               combo_start = r.time_ticks;
            end
         end
         // The tick difference wraps modulo 2^32.
         if (combo_seen != TRACK_IDLE && (r.time_ticks - combo_start) > hold_reg) begin
            if (combo_seen == TRACK_RESTART) begin
               rsp.reset_tap = 1'b1;
            end else begin
               org_stick_x = r.stick_x;
               org_stick_y = r.stick_y;
               org_sub_x   = r.substick_x;
               org_sub_y   = r.substick_y;
               org_trig_l  = r.trigger_left;
               org_trig_r  = r.trigger_right;
            end
            combo_seen = TRACK_IDLE;
         end
      end
      rsp.origin_stick_x       = org_stick_x;
      rsp.origin_stick_y       = org_stick_y;
      rsp.origin_substick_x    = org_sub_x;
      rsp.origin_substick_y    = org_sub_y;
      rsp.origin_trigger_left  = org_trig_l;
      rsp.origin_trigger_right = org_trig_r;
      owed_responses.push_back(rsp);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("response field %s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Sample all three channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         mode_reg    = MODE_RESET;
         hold_reg    = HOLD_RESET;
         combo_seen  = TRACK_IDLE;
         combo_start = 32'd0;
         org_stick_x = ORIGIN_STICK_RESET;
         org_stick_y = ORIGIN_STICK_RESET;
         org_sub_x   = ORIGIN_STICK_RESET;
         org_sub_y   = ORIGIN_STICK_RESET;
         org_trig_l  = ORIGIN_TRIG_RESET;
         org_trig_r  = ORIGIN_TRIG_RESET;
         owed_responses.delete();
      end else begin
         // Responses are checked first so that a response cannot be matched
         // against a request accepted at the same edge.
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got_rsp.word_hi              = rsp_ch.word_hi;
            got_rsp.word_lo              = rsp_ch.word_lo;
            got_rsp.reset_tap            = rsp_ch.reset_tap;
            got_rsp.origin_stick_x       = rsp_ch.origin_stick_x;
            got_rsp.origin_stick_y       = rsp_ch.origin_stick_y;
            got_rsp.origin_substick_x    = rsp_ch.origin_substick_x;
            got_rsp.origin_substick_y    = rsp_ch.origin_substick_y;
            got_rsp.origin_trigger_left  = rsp_ch.origin_trigger_left;
            got_rsp.origin_trigger_right = rsp_ch.origin_trigger_right;
            if (owed_responses.size() == 0) begin
               $error("response transaction with no request outstanding: hi 0x%0h lo 0x%0h",
                      got_rsp.word_hi, got_rsp.word_lo);
               error_count++;
            end else begin
               due_rsp = owed_responses.pop_front();
               check_field("word_hi", due_rsp.word_hi, got_rsp.word_hi);
               check_field("word_lo", due_rsp.word_lo, got_rsp.word_lo);
               check_field("reset_tap", 32'(due_rsp.reset_tap),
                           32'(got_rsp.reset_tap));
               check_field("origin_stick_x", 32'(due_rsp.origin_stick_x),
                           32'(got_rsp.origin_stick_x));
               check_field("origin_stick_y", 32'(due_rsp.origin_stick_y),
                           32'(got_rsp.origin_stick_y));
               check_field("origin_substick_x", 32'(due_rsp.origin_substick_x),
                           32'(got_rsp.origin_substick_x));
               check_field("origin_substick_y", 32'(due_rsp.origin_substick_y),
                           32'(got_rsp.origin_substick_y));
               check_field("origin_trigger_left", 32'(due_rsp.origin_trigger_left),
                           32'(got_rsp.origin_trigger_left));
               check_field("origin_trigger_right", 32'(due_rsp.origin_trigger_right),
                           32'(got_rsp.origin_trigger_right));
            end
         end

         // Register writes only take effect for later requests.
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1) begin
            if (csr_ch.index == REG_MODE) begin
               mode_reg = csr_ch.data[7:0];
            end else if (csr_ch.index == REG_HOLD) begin
               hold_reg = csr_ch.data;
            end
         end

         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            seen_req.kind          = req_ch.kind;
            seen_req.time_ticks    = req_ch.time_ticks;
            seen_req.buttons       = req_ch.buttons;
            seen_req.stick_x       = req_ch.stick_x;
            seen_req.stick_y       = req_ch.stick_y;
            seen_req.substick_x    = req_ch.substick_x;
            seen_req.substick_y    = req_ch.substick_y;
            seen_req.trigger_left  = req_ch.trigger_left;
            seen_req.trigger_right = req_ch.trigger_right;
            seen_req.analog_a      = req_ch.analog_a;
            seen_req.analog_b      = req_ch.analog_b;
            predict_poll_response(seen_req);
         end
      end
      pending = owed_responses.size();
   end

endmodule

// ----- tb/sv/pad_poll_response_packer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Pad poll response packer testbench
// Drives directed polls (field extremes, both combos, tick wraparound, origin
// reads inside a held combo) and then random phases that each program a mode
// and a hold time. Most random traffic is held combos with advancing ticks,
// the rest is noise. Sender and receiver stall at random except in the last three
// phases; the checker beside the block predicts and compares every response transaction.
// ----------------------------------------------------------------------------
module pad_poll_response_packer_unit_tb;
   import ppr_pkg::*;

   localparam int PHASE_ITEMS = 45;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   pending;
   int   req_idle_pct;
   int   rsp_idle_pct;
   logic [31:0] tick_now;

   ppr_req_if req_ch();
   ppr_rsp_if rsp_ch();
   ppr_csr_if csr_ch();

   pad_poll_response_packer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pad_poll_response_packer_checker response_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (error_count),
      .pending     (pending)
   );

   always #2 clock = ~clock;

   // Receiver: ready changes only at the falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= (rsp_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Give up if the run hangs.
   initial begin
      #400000;
      $display("pad_poll_response_packer_unit_tb: done, errors");
      $finish;
   end

   function automatic req_item_type random_pad_state();
      req_item_type r;
      r.kind          = 1'($urandom_range(1));
      r.time_ticks    = $urandom();
      r.buttons       = 16'($urandom());
      r.stick_x       = 8'($urandom());
      r.stick_y       = 8'($urandom());
      r.substick_x    = 8'($urandom());
      r.substick_y    = 8'($urandom());
      r.trigger_left  = 8'($urandom());
      r.trigger_right = 8'($urandom());
      r.analog_a      = 8'($urandom());
      r.analog_b      = 8'($urandom());
      return r;
   endfunction

   // Present one request and hold it until the transaction completes. Called
   // at a falling edge; returns at the falling edge after acceptance with
   // valid still high.
   task automatic drive_request(input req_item_type r);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= r.kind;
      req_ch.time_ticks    <= r.time_ticks;
      req_ch.buttons       <= r.buttons;
      req_ch.stick_x       <= r.stick_x;
      req_ch.stick_y       <= r.stick_y;
      req_ch.substick_x    <= r.substick_x;
      req_ch.substick_y    <= r.substick_y;
      req_ch.trigger_left  <= r.trigger_left;
      req_ch.trigger_right <= r.trigger_right;
      req_ch.analog_a      <= r.analog_a;
      req_ch.analog_b      <= r.analog_b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_poll(input logic [31:0] t, input logic [15:0] btn);
      req_item_type r;
      r            = random_pad_state();
      r.kind       = KIND_POLL;
      r.time_ticks = t;
      r.buttons    = btn;
      drive_request(r);
   endtask

   // An origin read carries random junk in every other field.
   task automatic send_origin_read();
      req_item_type r;
      r      = random_pad_state();
      r.kind = KIND_ORIGIN_READ;
      drive_request(r);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait until every response has been taken.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Reset values, extremes, both combos and their corner cases.
   task automatic run_directed();
      req_item_type r;
      send_origin_read();
      r      = '0;
      r.kind = KIND_POLL;
      drive_request(r);
      r      = '1;
      r.kind = KIND_POLL;
      drive_request(r);
      // Origin combo: a difference equal to the hold time does not act, one
      // more tick does; an origin read in between leaves the combo alone.
      send_poll(32'd100, {COMBO_MASK_ORIGIN, 8'h00});
      send_poll(32'd100 + HOLD_RESET, {COMBO_MASK_ORIGIN, 8'hA5});
      send_origin_read();
      send_poll(32'd101 + HOLD_RESET, {COMBO_MASK_ORIGIN, 8'hFF});
      send_origin_read();
      // Switching between combos restarts the timer.
      send_poll(32'hFFFF_FF00, {COMBO_MASK_RESET, 8'hFF});
      send_poll(32'hFFFF_FF10, {COMBO_MASK_ORIGIN, 8'h3C});
      send_poll(32'hFFFF_FF20, {COMBO_MASK_RESET, 8'h00});
      // Reset combo across the tick wraparound, then restarted right away.
      send_poll(32'hFFFF_FF21 + HOLD_RESET, {COMBO_MASK_RESET, 8'h5A});
      send_poll(32'hFFFF_FF26 + HOLD_RESET, {COMBO_MASK_RESET, 8'h0F});
      // Near misses: every upper bit set, and the origin combo plus bit 13.
      send_poll(32'hFFFF_FF30 + HOLD_RESET, 16'hFF00);
      send_poll(32'hFFFF_FF40 + HOLD_RESET, {COMBO_MASK_ORIGIN | 8'h20, 8'h00});
      send_origin_read();
      tick_now = 32'hFFFF_FF40 + HOLD_RESET;
      drain_responses();
   endtask

   // One register setting followed by random traffic.
   task automatic run_phase(input logic [7:0] mode_val, input logic [31:0] hold_val);
      int          sent;
      int          run_len;
      logic [7:0]  combo_bits;
      logic [31:0] step_max;
      write_register(REG_MODE, {24'd0, mode_val});
      write_register(REG_HOLD, hold_val);
      csr_ch.valid <= 1'b0;
      step_max = (hold_val >> 1) + 32'd3;
      sent     = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(99) < 65) begin
            // A held combo with advancing ticks and the odd origin read.
            combo_bits = $urandom_range(1) ? COMBO_MASK_ORIGIN : COMBO_MASK_RESET;
            run_len    = $urandom_range(7, 2);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(9) == 0) begin
                  send_origin_read();
               end else begin
                  tick_now = tick_now + $urandom_range(step_max);
                  send_poll(tick_now, {combo_bits, 8'($urandom())});
               end
               sent++;
            end
         end else begin
            case ($urandom_range(3))
               0: send_origin_read();
               1: begin
                  // Tick jump to anywhere, including backwards.
                  tick_now = $urandom();
                  send_poll(tick_now, 16'($urandom()));
               end
               2: begin
                  // Combo pattern with one button wrong.
                  combo_bits = $urandom_range(1) ? COMBO_MASK_ORIGIN : COMBO_MASK_RESET;
                  tick_now   = tick_now + $urandom_range(step_max);
                  send_poll(tick_now, {combo_bits ^ (8'd1 << $urandom_range(7)),
                                       8'($urandom())});
               end
               default: begin
                  tick_now = tick_now + $urandom_range(step_max);
                  send_poll(tick_now, 16'($urandom()));
               end
            endcase
            sent++;
         end
      end
      drain_responses();
   endtask

   // Stimulus and verdict.
   initial begin
      reset          = 1'b1;
      req_idle_pct   = 31;
      rsp_idle_pct   = 53;
      tick_now       = 32'd0;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_POLL;
      req_ch.time_ticks    = 32'd0;
      req_ch.buttons       = 16'd0;
      req_ch.stick_x       = 8'd0;
      req_ch.stick_y       = 8'd0;
      req_ch.substick_x    = 8'd0;
      req_ch.substick_y    = 8'd0;
      req_ch.trigger_left  = 8'd0;
      req_ch.trigger_right = 8'd0;
      req_ch.analog_a      = 8'd0;
      req_ch.analog_b      = 8'd0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_MODE;
      csr_ch.data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(MODE_NIBBLE_ALL, 32'd0);
      run_phase(MODE_FULL_TRIG, 32'd40);
      run_phase(MODE_FULL_ANALOG, 32'd1000);

      req_idle_pct = 53;
      rsp_idle_pct = 31;
      run_phase(MODE_NO_TRIG, 32'hFFFF_FFFF);
      run_phase(MODE_ALIAS_5, 32'd1);
      run_phase(MODE_ALIAS_6, 32'd200);
      run_phase(MODE_ALIAS_7, 32'd7);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(8'($urandom_range(254, 8)), 32'($urandom_range(500)));
      run_phase(8'hFF, 32'd20);
      run_phase(MODE_NO_ANALOG, HOLD_RESET);

      // Keep watching for stray responses before the verdict.
      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("pad_poll_response_packer_unit_tb: done, clean");
      end else begin
         $display("pad_poll_response_packer_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
